/* hw/rtl/bcf_pkg.sv */
// ----------------------------------------------------------------------------
// bcf_pkg
// Shared types, widths and the step table of the Bezier curve flattener.
// ----------------------------------------------------------------------------
package bcf_pkg;

	localparam int COORD_W = 16;
	localparam int STEP_W  = 6;
	localparam int T_W     = 17;
	localparam int SQ_W    = 33;
	localparam int WGT_W   = 49;
	localparam int PROD_W  = WGT_W + COORD_W;
	localparam int NPTS    = 4;
	localparam int NSTEPS  = 1 << STEP_W;
	localparam logic [STEP_W-1:0] STEPS_RESET = STEP_W'(10);

	typedef logic [T_W-1:0] t_val_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [NPTS-1:0][WGT_W-1:0] weights_t;
	typedef coord_t [NPTS-1:0] points_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} tag_t;

	typedef struct packed {
		logic [T_W-1:0]    quo;
		logic [STEP_W-1:0] rem;
	} div_entry_t;

	typedef div_entry_t [NSTEPS-1:0] div_tab_t;

	// 2^16 / n as quotient and remainder for every nonzero step count n; entry 0 holds zero.
	function automatic div_tab_t build_div_tab();
		div_tab_t tab;
		int       rem;
		int       quo;
		int       num;
		num = 1 << (T_W - 1);
		for (int n = 0; n < NSTEPS; n++) begin
			rem = 0;
			quo = 0;
			if (n != 0) begin
				for (int b = T_W - 1; b >= 0; b--) begin
					rem = (rem << 1) | ((num >> b) & 1);
					quo = quo << 1;
					if (rem >= n) begin
						rem = rem - n;
						quo = quo | 1;
					end
				end
			end
			tab[n].quo = T_W'(quo);
			tab[n].rem = STEP_W'(rem);
		end
		return tab;
	endfunction

	localparam div_tab_t DIV_TAB = build_div_tab();

endpackage

/* hw/rtl/bcf_step_gen.sv */
// ----------------------------------------------------------------------------
// bcf_step_gen
// Step sequencer: issues t = k/N in Q1.16 for k = 0..N, one step per beat.
// ----------------------------------------------------------------------------
module bcf_step_gen (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        start,
	input  logic [bcf_pkg::STEP_W-1:0]  steps,
	output logic                        busy,
	output bcf_pkg::t_val_t             t_s1,
	output bcf_pkg::tag_t               tag_s1
);

	logic                       busy_q;
	logic [bcf_pkg::STEP_W-1:0] k_q;
	logic [bcf_pkg::STEP_W-1:0] n_q;
	logic [bcf_pkg::T_W-1:0]    quo_q;
	logic [bcf_pkg::STEP_W-1:0] rem_q;
	logic [bcf_pkg::T_W-1:0]    acc_q;
	logic [bcf_pkg::STEP_W-1:0] frac_q;
	logic [bcf_pkg::STEP_W-1:0] n_eff;
	logic [bcf_pkg::STEP_W:0]   frac_sum;
	logic                       wrap;
	logic                       valid_s1;
	logic                       first_s1;
	logic                       last_s1;

	assign n_eff    = (steps == '0) ? bcf_pkg::STEP_W'(1) : steps;
	assign frac_sum = {1'b0, frac_q} + {1'b0, rem_q};
	assign wrap     = frac_sum >= {1'b0, n_q};
	assign busy     = busy_q;
	assign tag_s1   = '{valid: valid_s1, first: first_s1, last: last_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
			end else if (adv && busy_q && k_q == n_q) begin
				busy_q <= 1'b0;
			end
			if (adv) begin
				valid_s1 <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			k_q    <= '0;
			n_q    <= n_eff;
			quo_q  <= bcf_pkg::DIV_TAB[n_eff].quo;
			rem_q  <= bcf_pkg::DIV_TAB[n_eff].rem;
			acc_q  <= '0;
			frac_q <= n_eff >> 1;
		end else if (adv && busy_q) begin
			k_q <= k_q + bcf_pkg::STEP_W'(1);
			if (wrap) begin
				frac_q <= bcf_pkg::STEP_W'(frac_sum - {1'b0, n_q});
				acc_q  <= acc_q + quo_q + bcf_pkg::T_W'(1);
			end else begin
				frac_q <= frac_sum[bcf_pkg::STEP_W-1:0];
				acc_q  <= acc_q + quo_q;
			end
		end
		if (adv) begin
			t_s1     <= acc_q;
			first_s1 <= k_q == '0;
			last_s1  <= k_q == n_q;
		end
	end

endmodule

/* hw/rtl/bcf_weights.sv */
// ----------------------------------------------------------------------------
// bcf_weights
// Two pipeline stages forming the Bernstein weights in Q1.48 from t.
// ----------------------------------------------------------------------------
module bcf_weights (
	input  logic                clk,
	input  logic                adv,
	input  logic                cubic,
	input  bcf_pkg::t_val_t     t_s1,
	output bcf_pkg::weights_t   w_s3
);

	localparam int M1_W = 2 * bcf_pkg::T_W;
	localparam int M2_W = bcf_pkg::SQ_W + bcf_pkg::T_W + 2;

	logic [bcf_pkg::T_W-1:0]  u;
	logic [M1_W-1:0]          uu_full;
	logic [M1_W-1:0]          ut_full;
	logic [M1_W-1:0]          tt_full;
	logic [bcf_pkg::SQ_W-1:0] uu_s2;
	logic [bcf_pkg::SQ_W-1:0] ut_s2;
	logic [bcf_pkg::SQ_W-1:0] tt_s2;
	logic [bcf_pkg::T_W-1:0]  u_s2;
	logic [bcf_pkg::T_W-1:0]  t_s2;
	logic [M2_W-1:0]          c0;
	logic [M2_W-1:0]          c1;
	logic [M2_W-1:0]          c2;
	logic [M2_W-1:0]          c3;
	bcf_pkg::weights_t        w_next;

	assign u       = bcf_pkg::T_W'(1 << (bcf_pkg::T_W - 1)) - t_s1;
	assign uu_full = u * u;
	assign ut_full = u * t_s1;
	assign tt_full = t_s1 * t_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			uu_s2 <= uu_full[bcf_pkg::SQ_W-1:0];
			ut_s2 <= ut_full[bcf_pkg::SQ_W-1:0];
			tt_s2 <= tt_full[bcf_pkg::SQ_W-1:0];
			u_s2  <= u;
			t_s2  <= t_s1;
		end
	end

	assign c0 = M2_W'(uu_s2) * M2_W'(u_s2);
	assign c1 = M2_W'(uu_s2) * M2_W'(t_s2);
	assign c2 = M2_W'(tt_s2) * M2_W'(u_s2);
	assign c3 = M2_W'(tt_s2) * M2_W'(t_s2);

	always_comb begin
		if (cubic) begin
			w_next[0] = bcf_pkg::WGT_W'(c0);
			w_next[1] = bcf_pkg::WGT_W'(c1 + (c1 << 1));
			w_next[2] = bcf_pkg::WGT_W'(c2 + (c2 << 1));
			w_next[3] = bcf_pkg::WGT_W'(c3);
		end else begin
			w_next[0] = bcf_pkg::WGT_W'({uu_s2, 16'd0});
			w_next[1] = bcf_pkg::WGT_W'({ut_s2, 17'd0});
			w_next[2] = '0;
			w_next[3] = bcf_pkg::WGT_W'({tt_s2, 16'd0});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s3 <= w_next;
		end
	end

endmodule

/* hw/rtl/bcf_blend.sv */
// ----------------------------------------------------------------------------
// bcf_blend
// Weighted sum of four coordinates of one axis, rounded to nearest.
// ----------------------------------------------------------------------------
module bcf_blend (
	input  logic              clk,
	input  logic              adv,
	input  bcf_pkg::weights_t w_s3,
	input  bcf_pkg::points_t  pts,
	output bcf_pkg::coord_t   res
);

	localparam int SUM_W = bcf_pkg::PROD_W + 2;
	localparam int SHIFT = bcf_pkg::WGT_W - 1;

	logic [bcf_pkg::NPTS-1:0][bcf_pkg::PROD_W-1:0] prod_s4;
	logic [SUM_W-1:0] pair0_s5;
	logic [SUM_W-1:0] pair1_s5;
	logic [SUM_W-1:0] total;
	logic [SUM_W-SHIFT-1:0] r;
	logic [bcf_pkg::COORD_W-1:0] r_sat;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < bcf_pkg::NPTS; i++) begin
				prod_s4[i] <= bcf_pkg::PROD_W'(w_s3[i]) *
					bcf_pkg::PROD_W'({~pts[i][bcf_pkg::COORD_W-1],
						pts[i][bcf_pkg::COORD_W-2:0]});
			end
			pair0_s5 <= SUM_W'(prod_s4[0]) + SUM_W'(prod_s4[1]);
			pair1_s5 <= SUM_W'(prod_s4[2]) + SUM_W'(prod_s4[3]);
		end
	end

	assign total = pair0_s5 + pair1_s5 + (SUM_W'(1) << (SHIFT - 1));
	assign r     = total[SUM_W-1:SHIFT];
	assign r_sat = (r > (SUM_W-SHIFT)'({bcf_pkg::COORD_W{1'b1}})) ?
		{bcf_pkg::COORD_W{1'b1}} : r[bcf_pkg::COORD_W-1:0];
	assign res   = {~r_sat[bcf_pkg::COORD_W-1], r_sat[bcf_pkg::COORD_W-2:0]};

endmodule

/* hw/rtl/bezier_curve_flattener.sv */
// ----------------------------------------------------------------------------
// bezier_curve_flattener
// Flattens one quadratic or cubic Bezier curve into N+1 line segments.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  in      | in_valid / in_stall        | mode, start, ctrl1, ctrl2, end
//  out     | out_valid / out_stall      | from, to, last_segment
//  cfg     | cfg_wr_en                  | cfg_wr_data (steps_per_curve)
//
// A curve gives N+1 output beats, one per cycle when out is not stalled,
// through a six-stage pipeline.
// A new curve is taken once the previous one has left stage five; its last beat may still wait in the output register.
// Reset clears all valid bits and sets the step count to ten.
// Out stall freezes the whole pipeline while a beat waits at the output; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module bezier_curve_flattener (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [bcf_pkg::STEP_W-1:0]          cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode,
	input  logic signed [bcf_pkg::COORD_W-1:0]  start_x,
	input  logic signed [bcf_pkg::COORD_W-1:0]  start_y,
	input  logic signed [bcf_pkg::COORD_W-1:0]  ctrl1_x,
	input  logic signed [bcf_pkg::COORD_W-1:0]  ctrl1_y,
	input  logic signed [bcf_pkg::COORD_W-1:0]  ctrl2_x,
	input  logic signed [bcf_pkg::COORD_W-1:0]  ctrl2_y,
	input  logic signed [bcf_pkg::COORD_W-1:0]  end_x,
	input  logic signed [bcf_pkg::COORD_W-1:0]  end_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [bcf_pkg::COORD_W-1:0]  from_x,
	output logic signed [bcf_pkg::COORD_W-1:0]  from_y,
	output logic signed [bcf_pkg::COORD_W-1:0]  to_x,
	output logic signed [bcf_pkg::COORD_W-1:0]  to_y,
	output logic                                last_segment
);

	logic [bcf_pkg::STEP_W-1:0] steps_q;
	logic                       cubic_q;
	bcf_pkg::points_t           px_q;
	bcf_pkg::points_t           py_q;
	logic                       adv;
	logic                       accept;
	logic                       gen_busy;
	bcf_pkg::t_val_t            t_s1;
	bcf_pkg::tag_t              tag_s1;
	bcf_pkg::tag_t              tag_s2;
	bcf_pkg::tag_t              tag_s3;
	bcf_pkg::tag_t              tag_s4;
	bcf_pkg::tag_t              tag_s5;
	bcf_pkg::weights_t          w_s3;
	bcf_pkg::coord_t            res_x;
	bcf_pkg::coord_t            res_y;
	bcf_pkg::coord_t            prev_x_q;
	bcf_pkg::coord_t            prev_y_q;
	logic                       out_valid_q;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = gen_busy || tag_s1.valid || tag_s2.valid || tag_s3.valid ||
		tag_s4.valid || tag_s5.valid;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= bcf_pkg::STEPS_RESET;
		end else if (cfg_wr_en) begin
			steps_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cubic_q <= mode;
			px_q    <= {end_x, ctrl2_x, ctrl1_x, start_x};
			py_q    <= {end_y, ctrl2_y, ctrl1_y, start_y};
		end
	end

	bcf_step_gen u_step_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.start  (accept),
		.steps  (steps_q),
		.busy   (gen_busy),
		.t_s1   (t_s1),
		.tag_s1 (tag_s1)
	);

	bcf_weights u_weights (
		.clk   (clk),
		.adv   (adv),
		.cubic (cubic_q),
		.t_s1  (t_s1),
		.w_s3  (w_s3)
	);

	bcf_blend u_blend_x (
		.clk  (clk),
		.adv  (adv),
		.w_s3 (w_s3),
		.pts  (px_q),
		.res  (res_x)
	);

	bcf_blend u_blend_y (
		.clk  (clk),
		.adv  (adv),
		.w_s3 (w_s3),
		.pts  (py_q),
		.res  (res_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2      <= '0;
			tag_s3      <= '0;
			tag_s4      <= '0;
			tag_s5      <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			tag_s2      <= tag_s1;
			tag_s3      <= tag_s2;
			tag_s4      <= tag_s3;
			tag_s5      <= tag_s4;
			out_valid_q <= tag_s5.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tag_s5.valid) begin
			to_x         <= res_x;
			to_y         <= res_y;
			from_x       <= tag_s5.first ? res_x : prev_x_q;
			from_y       <= tag_s5.first ? res_y : prev_y_q;
			last_segment <= tag_s5.last;
			prev_x_q     <= res_x;
			prev_y_q     <= res_y;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* bench/bezier_curve_flattener_tb.sv */
// ----------------------------------------------------------------------------
// bezier_curve_flattener_tb
// Sends quadratic and cubic curves through the flattener under several step
// counts and handshake pressures. Every output beat is checked against
// segments predicted from exact integer Bernstein evaluation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bezier_curve_flattener_tb;

	localparam logic CURVE_QUAD  = 1'b0;
	localparam logic CURVE_CUBIC = 1'b1;
	localparam int   DRAIN_CYCLES = 24;

	typedef struct {
		logic            cubic;
		bcf_pkg::coord_t pt [8];
	} curve_t;

	typedef struct {
		bcf_pkg::coord_t fx, fy, tx, ty;
		logic            last;
	} segment_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [bcf_pkg::STEP_W-1:0] cfg_wr_data;
	logic in_valid, in_stall, mode;
	bcf_pkg::coord_t start_x, start_y, ctrl1_x, ctrl1_y;
	bcf_pkg::coord_t ctrl2_x, ctrl2_y, end_x, end_y;
	logic out_valid, out_stall, last_segment;
	bcf_pkg::coord_t from_x, from_y, to_x, to_y;

	segment_t segment_q [$];
	logic [bcf_pkg::STEP_W-1:0] steps_cfg;
	int send_idle_pct;
	int stall_pct;
	bit failed;

	bezier_curve_flattener dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode),
		.start_x(start_x), .start_y(start_y), .ctrl1_x(ctrl1_x), .ctrl1_y(ctrl1_y),
		.ctrl2_x(ctrl2_x), .ctrl2_y(ctrl2_y), .end_x(end_x), .end_y(end_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.from_x(from_x), .from_y(from_y), .to_x(to_x), .to_y(to_y),
		.last_segment(last_segment)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12.0 * 3000000);
		$display("Verification failed");
		$finish;
	end

	// Weighted sum of offset-binary coordinates, rounded and clamped.
	function automatic bcf_pkg::coord_t mix_points(logic [63:0] w [4],
		bcf_pkg::coord_t p [4], int cnt);
		logic [127:0] acc;
		logic [127:0] r;
		logic [15:0]  q;
		acc = 0;
		for (int i = 0; i < cnt; i++) begin
			q = p[i] ^ 16'h8000;
			acc += 128'(w[i]) * 128'(q);
		end
		r = (acc + (128'd1 << 47)) >> 48;
		if (r > 128'hFFFF)
			r = 128'hFFFF;
		return bcf_pkg::coord_t'(r[15:0] ^ 16'h8000);
	endfunction

	function automatic bcf_pkg::coord_t bernstein(curve_t c, logic [63:0] t, int axis);
		logic [63:0] u;
		logic [63:0] w [4];
		bcf_pkg::coord_t p [4];
		u = 64'd65536 - t;
		p[0] = c.pt[axis];
		p[1] = c.pt[2 + axis];
		if (c.cubic) begin
			w[0] = u * u * u;
			w[1] = 3 * u * u * t;
			w[2] = 3 * u * t * t;
			w[3] = t * t * t;
			p[2] = c.pt[4 + axis];
			p[3] = c.pt[6 + axis];
			return mix_points(w, p, 4);
		end
		w[0] = (u * u) << 16;
		w[1] = (2 * u * t) << 16;
		w[2] = (t * t) << 16;
		w[3] = 0;
		p[2] = c.pt[6 + axis];
		p[3] = 0;
		return mix_points(w, p, 3);
	endfunction

	task automatic predict_segments(curve_t c);
		logic [63:0] n;
		logic [63:0] t;
		bcf_pkg::coord_t px, py, nx, ny;
		segment_t s;
		n = (steps_cfg == 0) ? 64'd1 : 64'(steps_cfg);
		px = c.pt[0];
		py = c.pt[1];
		for (logic [63:0] k = 0; k <= n; k++) begin
			t = (k * 64'd65536 + n / 2) / n;
			nx = bernstein(c, t, 0);
			ny = bernstein(c, t, 1);
			s.fx = px; s.fy = py; s.tx = nx; s.ty = ny;
			s.last = (k == n);
			segment_q.push_back(s);
			px = nx;
			py = ny;
		end
	endtask

	task automatic send_curve(curve_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= c.cubic;
		start_x <= c.pt[0]; start_y <= c.pt[1];
		ctrl1_x <= c.pt[2]; ctrl1_y <= c.pt[3];
		ctrl2_x <= c.pt[4]; ctrl2_y <= c.pt[5];
		end_x <= c.pt[6]; end_y <= c.pt[7];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_segments(c);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (segment_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_steps(logic [bcf_pkg::STEP_W-1:0] n);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= n;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		steps_cfg = n;
		@(posedge clk);
	endtask

	function automatic bcf_pkg::coord_t rand_coord();
		case ($urandom_range(5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return bcf_pkg::coord_t'($urandom_range(64)) - 16'sd32;
			default: return bcf_pkg::coord_t'($urandom);
		endcase
	endfunction

	function automatic curve_t rand_curve();
		curve_t c;
		c.cubic = $urandom_range(1);
		for (int i = 0; i < 8; i++)
			c.pt[i] = rand_coord();
		return c;
	endfunction

	function automatic curve_t flat_curve(logic cubic, bcf_pkg::coord_t v);
		curve_t c;
		c.cubic = cubic;
		for (int i = 0; i < 8; i++)
			c.pt[i] = v;
		return c;
	endfunction

	// Output side: random stall and in-order comparison.
	always @(posedge clk) begin
		segment_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (segment_q.size() == 0) begin
					$display("%0t: unexpected beat from (%0d,%0d) to (%0d,%0d) last %0b",
						$time, from_x, from_y, to_x, to_y, last_segment);
					failed = 1'b1;
				end else begin
					e = segment_q.pop_front();
					if (from_x !== e.fx || from_y !== e.fy || to_x !== e.tx ||
						to_y !== e.ty || last_segment !== e.last) begin
						$display("%0t: expected (%0d,%0d)->(%0d,%0d) last %0b, got (%0d,%0d)->(%0d,%0d) last %0b",
							$time, e.fx, e.fy, e.tx, e.ty, e.last,
							from_x, from_y, to_x, to_y, last_segment);
						failed = 1'b1;
					end
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic test_directed();
		curve_t c;
		send_curve(flat_curve(CURVE_QUAD, 16'sh7FFF));
		send_curve(flat_curve(CURVE_CUBIC, 16'sh7FFF));
		send_curve(flat_curve(CURVE_QUAD, 16'sh8000));
		send_curve(flat_curve(CURVE_CUBIC, 16'sh8000));
		send_curve(flat_curve(CURVE_CUBIC, 16'sh0000));
		send_curve(flat_curve(CURVE_QUAD, -16'sd1));
		c = flat_curve(CURVE_CUBIC, 16'sh8000);
		c.pt[2] = 16'sh7FFF; c.pt[5] = 16'sh7FFF; c.pt[6] = 16'sh7FFF;
		send_curve(c);
		c.cubic = CURVE_QUAD;
		send_curve(c);
		c = flat_curve(CURVE_QUAD, 16'sh7FFF);
		c.pt[4] = 16'sh8000; c.pt[5] = 16'sh8000;
		send_curve(c);
		c.pt[1] = 16'sh8000; c.pt[7] = 16'sh5555; c.pt[3] = 16'shAAAA;
		send_curve(c);
		c.cubic = CURVE_CUBIC;
		send_curve(c);
	endtask

	task automatic test_step_extremes();
		logic [bcf_pkg::STEP_W-1:0] counts [4] = '{6'd0, 6'd1, 6'd63, 6'd2};
		foreach (counts[i]) begin
			write_steps(counts[i]);
			for (int j = 0; j < 3; j++)
				send_curve(rand_curve());
		end
	endtask

	task automatic test_random_phase(int idle, int stall, int items);
		send_idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < items; i++) begin
			if (i % 40 == 0)
				write_steps(($urandom_range(7) == 0) ? 6'($urandom_range(63))
					: 6'($urandom_range(12)));
			send_curve(rand_curve());
		end
	endtask

	task automatic test_pause_until_empty();
		send_curve(rand_curve());
		drain();
		send_curve(rand_curve());
		send_curve(rand_curve());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		mode = 1'b0;
		{start_x, start_y, ctrl1_x, ctrl1_y} = '0;
		{ctrl2_x, ctrl2_y, end_x, end_y} = '0;
		out_stall = 1'b0;
		steps_cfg = bcf_pkg::STEPS_RESET;
		send_idle_pct = 0;
		stall_pct = 0;
		failed = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_step_extremes();
		test_random_phase(0, 0, 120);
		test_random_phase(59, 0, 120);
		test_random_phase(0, 59, 120);
		test_random_phase(33, 33, 120);
		test_pause_until_empty();
		write_steps(bcf_pkg::STEPS_RESET);
		send_curve(rand_curve());
		drain();

		if (!failed)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
